FILE: hdl/pee_pkg.sv
// shared types and constants of the postfix expression evaluator
// no dependencies; used by every module of the block
package pee_pkg;

    localparam int DATA_W    = 32;
    localparam int SYM_W     = 8;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // ascii codes of the accepted symbols
    localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_INVALID   = 3'd3,
        ST_DIVZERO   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic div_commit;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/pee_div.sv
// iterative signed 32-bit divider, truncating toward zero, one quotient bit a cycle
// depends on pee_pkg
module pee_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pee_pkg::DATA_W-1:0]   dividend,
    input  logic [pee_pkg::DATA_W-1:0]   divisor,
    output logic                         done,
    output logic [pee_pkg::DATA_W-1:0]   quotient
);

    localparam logic [pee_pkg::DIV_CNT_W-1:0] CNT_LAST =
        pee_pkg::DIV_CNT_W'(pee_pkg::DATA_W - 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [pee_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [pee_pkg::DATA_W-1:0]     rem_reg, rem_next;
    logic [pee_pkg::DATA_W-1:0]     quo_reg, quo_next;
    logic [pee_pkg::DATA_W-1:0]     dvs_reg, dvs_next;
    logic                           neg_reg, neg_next;
    logic [pee_pkg::DATA_W:0]       shifted;
    logic [pee_pkg::DATA_W:0]       trial;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[pee_pkg::DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[pee_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[pee_pkg::DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[pee_pkg::DATA_W-1] ^ divisor[pee_pkg::DATA_W-1];
        end else if (busy_reg) begin
            if (!trial[pee_pkg::DATA_W]) begin
                rem_next = trial[pee_pkg::DATA_W-1:0];
                quo_next = {quo_reg[pee_pkg::DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[pee_pkg::DATA_W-1:0];
                quo_next = {quo_reg[pee_pkg::DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand and partial result registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

FILE: hdl/pee_dp.sv
// datapath: operand stack memory, top-of-stack register, alu, error latch, output register
// depends on pee_pkg and pee_div
module pee_dp #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pee_pkg::ctrl_cmd_t           cmd,
    output pee_pkg::dp_status_t          status,
    input  logic [pee_pkg::SYM_W-1:0]    s_symbol,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [pee_pkg::DATA_W-1:0] m_value,
    output logic [2:0]                   m_status
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    // the top of stack lives in tos_reg, the entries below it in the memory
    logic [pee_pkg::DATA_W-1:0]  mem [STACK_DEPTH];
    logic [pee_pkg::DATA_W-1:0]  rd_data_reg;
    logic [pee_pkg::DATA_W-1:0]  tos_reg, tos_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    pee_pkg::status_t            err_reg, err_next;
    logic [pee_pkg::SYM_W-1:0]   sym_reg;
    logic                        last_reg;
    logic                        mvalid_reg, mvalid_next;
    logic [pee_pkg::DATA_W-1:0]  mvalue_reg;
    pee_pkg::status_t            mstatus_reg;
    logic [CNT_W-1:0]            cnt_m1;
    logic [CNT_W-1:0]            cnt_m2;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        push_wr;
    logic                        is_digit;
    logic [pee_pkg::DATA_W-1:0]  lhs;
    logic [pee_pkg::DATA_W-1:0]  rhs;
    logic [pee_pkg::DATA_W-1:0]  mul_res;
    logic                        div_done;
    logic [pee_pkg::DATA_W-1:0]  div_q;
    logic                        div_start;

    assign cnt_m1  = cnt_reg - 1'b1;
    assign cnt_m2  = cnt_reg - CNT_TWO;
    assign wr_addr = cnt_m1[ADDR_W-1:0];
    assign rd_addr = cnt_m2[ADDR_W-1:0];

    assign is_digit = sym_reg inside {[pee_pkg::CHAR_ZERO:pee_pkg::CHAR_NINE]};
    assign lhs      = rd_data_reg;
    assign rhs      = tos_reg;
    assign mul_res  = lhs * rhs;

    // division is needed only for a valid slash with a nonzero divisor
    assign status.need_div = (err_reg == pee_pkg::ST_OK) && (sym_reg == pee_pkg::CHAR_SLASH)
                             && (cnt_reg >= CNT_TWO) && (rhs != '0);
    assign status.last     = last_reg;
    assign status.div_done = div_done;
    assign status.out_free = !mvalid_reg || m_ready;

    assign div_start = cmd.exec && status.need_div;
    assign push_wr   = cmd.exec && (err_reg == pee_pkg::ST_OK) && is_digit
                       && (cnt_reg < CNT_FULL) && (cnt_reg != '0);

    pee_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lhs),
        .divisor  (rhs),
        .done     (div_done),
        .quotient (div_q)
    );

    // symbol evaluation, division commit and end-of-expression clear
    always_comb begin
        tos_next    = tos_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        mvalid_next = mvalid_reg && !m_ready;
        if (cmd.exec && (err_reg == pee_pkg::ST_OK)) begin
            if (is_digit) begin
                if (cnt_reg >= CNT_FULL) begin
                    err_next = pee_pkg::ST_OVERFLOW;
                end else begin
                    tos_next = {{(pee_pkg::DATA_W-pee_pkg::SYM_W){1'b0}},
                                sym_reg - pee_pkg::CHAR_ZERO};
                    cnt_next = cnt_reg + 1'b1;
                end
            end else if (cnt_reg < CNT_TWO) begin
                err_next = pee_pkg::ST_UNDERFLOW;
            end else begin
                case (sym_reg)
                    pee_pkg::CHAR_PLUS: begin
                        tos_next = lhs + rhs;
                        cnt_next = cnt_m1;
                    end
                    pee_pkg::CHAR_MINUS: begin
                        tos_next = lhs - rhs;
                        cnt_next = cnt_m1;
                    end
                    pee_pkg::CHAR_STAR: begin
                        tos_next = mul_res;
                        cnt_next = cnt_m1;
                    end
                    pee_pkg::CHAR_SLASH: begin
                        if (rhs == '0) begin
                            err_next = pee_pkg::ST_DIVZERO;
                        end
                    end
                    default: begin
                        err_next = pee_pkg::ST_INVALID;
                    end
                endcase
            end
        end
        if (cmd.div_commit) begin
            tos_next = div_q;
            cnt_next = cnt_m1;
        end
        if (cmd.finish) begin
            cnt_next    = '0;
            err_next    = pee_pkg::ST_OK;
            mvalid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            err_reg    <= pee_pkg::ST_OK;
            mvalid_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            err_reg    <= err_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        if (cmd.capture) begin
            sym_reg  <= s_symbol;
            last_reg <= s_last;
        end
        if (cmd.finish) begin
            if (err_reg != pee_pkg::ST_OK) begin
                mvalue_reg  <= '0;
                mstatus_reg <= err_reg;
            end else if (cnt_reg == '0) begin
                mvalue_reg  <= '0;
                mstatus_reg <= pee_pkg::ST_UNDERFLOW;
            end else begin
                mvalue_reg  <= tos_reg;
                mstatus_reg <= pee_pkg::ST_OK;
            end
        end
    end

    // stack memory: push spills the old top, reads fetch the entry below the top
    always_ff @(posedge aclk) begin
        if (push_wr) begin
            mem[wr_addr] <= tos_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_valid  = mvalid_reg;
    assign m_value  = mvalue_reg;
    assign m_status = mstatus_reg;

endmodule

FILE: hdl/pee_ctrl.sv
// controller state machine: sequences accept, evaluation, division wait and result
// depends on pee_pkg
module pee_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pee_pkg::dp_status_t  status,
    output pee_pkg::ctrl_cmd_t   cmd
);

    pee_pkg::state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pee_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = pee_pkg::S_EXEC;
                end
            end
            pee_pkg::S_EXEC: begin
                if (status.need_div) begin
                    state_next = pee_pkg::S_DIV;
                end else if (status.last) begin
                    state_next = pee_pkg::S_FINISH;
                end else begin
                    state_next = pee_pkg::S_IDLE;
                end
            end
            pee_pkg::S_DIV: begin
                if (status.div_done) begin
                    state_next = status.last ? pee_pkg::S_FINISH : pee_pkg::S_IDLE;
                end
            end
            pee_pkg::S_FINISH: begin
                if (status.out_free) begin
                    state_next = pee_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pee_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = (state_reg == pee_pkg::S_IDLE);
        cmd.capture    = (state_reg == pee_pkg::S_IDLE) && s_valid;
        cmd.exec       = (state_reg == pee_pkg::S_EXEC);
        cmd.div_commit = (state_reg == pee_pkg::S_DIV) && status.div_done;
        cmd.finish     = (state_reg == pee_pkg::S_FINISH) && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pee_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/postfix_expression_evaluator.sv
// postfix evaluator: a digit or + - * passes through the exec state before the next ready,
// a division also waits in the div state for the one-bit-per-cycle divider (32 steps)
// a symbol marked last adds a finish state that loads the output register once it is free;
// the result is registered there and waits in it while the next expression starts
// synchronous active-low reset empties the stack and clears the error and output valid
// no clearing pass: stack memory contents are only read below the fill count
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pee_pkg::SYM_W-1:0]         s_symbol,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pee_pkg::DATA_W-1:0] m_value,
    output logic [2:0]                        m_status
);

    pee_pkg::ctrl_cmd_t  cmd;
    pee_pkg::dp_status_t status;

    pee_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pee_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_symbol (s_symbol),
        .s_last   (s_last),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_status (m_status)
    );

endmodule
